### hw/rtl/tcw_pkg.sv
// Package with the shared word types, command codes and constants of the text console.
`default_nettype none

package tcw_pkg;

  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int CIDX_W = 11;
  localparam int CELL_W = 16;
  localparam int POS_W  = 11;
  localparam int OP_W   = 3;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [OP_W-1:0] OP_PUT     = 3'd0;
  localparam logic [OP_W-1:0] OP_NEWLINE = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd2;
  localparam logic [OP_W-1:0] OP_READ    = 3'd3;
  localparam logic [OP_W-1:0] OP_NOP     = 3'd4;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] NUL_CODE     = 8'h00;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

  localparam int          PADDR_W         = 3;
  localparam logic        REG_TEXT_COLOR  = 1'b0;
  localparam logic [7:0]  TEXT_COLOR_INIT = 8'h07;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_byte;
    logic [CIDX_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [POS_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0] serial_byte;
    logic              serial_valid;
    logic              scrolled;
  } res_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [CIDX_W-1:0] cidx;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/text_console_writer.sv
// Top level of the text console: queue ports, color register port and the three parts.
//
// The console keeps ROWS x COLUMNS cells of 16 bits (attribute byte high, character byte
// low) and a cursor. Input words carry func (put character, clear, read cell); every word
// gives exactly one result word with the read cell, the cursor position after the word,
// the serial echo and a scroll flag. Words enter through push/full and leave through
// pop/empty; a two-entry command queue and a two-entry result queue let both sides stall
// on their own. A put or newline that does not scroll and an unused func are answered in
// the cycle the engine takes them; a read goes through a read state, since the cell store
// has a registered read port. A put or newline that moves past the last row scrolls the
// store through its single read and single write port, one cell per cycle. A clear
// sweeps the store. After reset the store is filled with blank cells (space, grey on
// black) in one pass; full stays high during that pass. The text_color register sits at
// byte address 0 of the APB port and resets to 7; write it only while the console is idle.
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input word queue.
  input  wire logic               push,
  output logic                    full,
  input  wire item_t              item,
  // Result word queue.
  output logic                    empty,
  input  wire logic               pop,
  output res_t                    result,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [7:0] text_color;
  logic       fe_full;
  logic       init_busy;
  logic       cmd_valid;
  cmd_t       cmd;
  logic       cmd_pop;
  logic       res_push;
  res_t       res_word;
  logic       res_full;

  // The register sits in the lower word; the upper word of the map is unused.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, text_color} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= TEXT_COLOR_INIT;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_COLOR)) begin
      text_color <= pwdata[7:0];
    end
  end

  // Input words are held off while the reset fill pass runs.
  assign full = fe_full || init_busy;

  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push && !full),
    .item      (item),
    .full      (fe_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tcw_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .text_color (text_color),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .init_busy  (init_busy),
    .res_push   (res_push),
    .res_word   (res_word),
    .res_full   (res_full)
  );

  tcw_result_q u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_word),
    .full  (res_full),
    .empty (empty),
    .pop   (pop),
    .dout  (result)
  );

endmodule

`default_nettype wire

### hw/rtl/tcw_front.sv
// Front end: decodes incoming words into commands and holds them in a two-entry queue.
`default_nettype none

module tcw_front
  import tcw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t item,
  output logic       full,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  wire logic  cmd_pop
);

  cmd_t       entries [2];
  logic [1:0] count;
  logic       wp;
  logic       rp;
  cmd_t       dec;
  logic       do_push;
  logic       do_pop;

  // A put of the newline code moves the cursor only, so it gets its own command.
  always_comb begin
    dec.ch   = item.char_byte;
    dec.cidx = item.cell_index;
    case (item.func)
      FUNC_PUT: begin
        dec.op = (item.char_byte == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      end
      FUNC_CLEAR: begin
        dec.op = OP_CLEAR;
      end
      FUNC_READ: begin
        dec.op = OP_READ;
      end
      default: begin
        dec.op = OP_NOP;
      end
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tcw_engine.sv
// Back end: owns the cell store and the cursor, and carries out one command at a time.
`default_nettype none

module tcw_engine
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] text_color,
  input  wire logic       cmd_valid,
  input  wire cmd_t       cmd,
  output logic            cmd_pop,
  output logic            init_busy,
  output logic            res_push,
  output res_t            res_word,
  input  wire logic       res_full
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLUMNS);

  localparam logic [AW-1:0]  LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0]  TAIL_START = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0]  COPY_LAST  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0]  COLS_A     = AW'(COLUMNS);
  localparam logic [RW-1:0]  LAST_ROW   = RW'(ROWS - 1);
  localparam logic [CLW-1:0] LAST_COL   = CLW'(COLUMNS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_COPY  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_TAIL  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wa;
  logic [CELL_W-1:0] wd;

  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [AW-1:0]  cnt;
  logic [AW-1:0]  cnt_next;
  logic           do_push;
  logic           do_push_next;
  logic           pend;
  logic [AW-1:0]  copy_wa;

  logic [RW-1:0]  cur_row;
  logic [RW-1:0]  cur_row_next;
  logic [CLW-1:0] cur_col;
  logic [CLW-1:0] cur_col_next;
  logic [AW-1:0]  cur_pos;
  logic [AW-1:0]  cur_pos_next;

  logic [CHAR_W-1:0] sbyte_q;
  logic              svalid_q;
  logic              scr_q;
  logic              rok_q;

  logic take;
  logic is_put;
  logic is_nl;
  logic in_rng;
  logic adv_row;
  logic scroll;

  assign take      = (state == S_IDLE) && cmd_valid && !res_full;
  assign cmd_pop   = take;
  assign init_busy = (state == S_FILL) && !do_push;
  assign is_put    = (cmd.op == OP_PUT);
  assign is_nl     = (cmd.op == OP_NEWLINE);
  assign in_rng    = (32'(cmd.cidx) < CELLS);
  assign adv_row   = is_nl || (is_put && (cur_col == LAST_COL));
  assign scroll    = adv_row && (cur_row == LAST_ROW);

  // Cursor update happens when the command is taken, so the result shows the final position.
  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    cur_pos_next = cur_pos;
    if (take) begin
      if (cmd.op == OP_CLEAR) begin
        cur_row_next = '0;
        cur_col_next = '0;
        cur_pos_next = '0;
      end else if (scroll) begin
        cur_row_next = LAST_ROW;
        cur_col_next = '0;
        cur_pos_next = TAIL_START;
      end else if (adv_row) begin
        cur_row_next = cur_row + RW'(1);
        cur_col_next = '0;
        cur_pos_next = cur_pos - AW'(cur_col) + COLS_A;
      end else if (is_put) begin
        cur_col_next = cur_col + CLW'(1);
        cur_pos_next = cur_pos + AW'(1);
      end
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    do_push_next = do_push;
    res_push     = 1'b0;
    case (state)
      S_IDLE: begin
        if (take) begin
          if (cmd.op == OP_CLEAR) begin
            state_next   = S_FILL;
            cnt_next     = '0;
            do_push_next = 1'b1;
          end else if (scroll) begin
            state_next = S_COPY;
            cnt_next   = '0;
          end else if (cmd.op == OP_READ) begin
            state_next = S_READ;
          end else begin
            res_push = 1'b1;
          end
        end
      end
      S_FILL: begin
        cnt_next = cnt + AW'(1);
        if (cnt == LAST_CELL) begin
          state_next = S_IDLE;
          res_push   = do_push;
        end
      end
      S_COPY: begin
        cnt_next = cnt + AW'(1);
        if (cnt == COPY_LAST) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_TAIL;
        cnt_next   = TAIL_START;
      end
      S_TAIL: begin
        cnt_next = cnt + AW'(1);
        if (cnt == LAST_CELL) begin
          state_next = S_IDLE;
          res_push   = 1'b1;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
        res_push   = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Single write port: the delayed copy write, the fill sweeps, or a character cell.
  always_comb begin
    we = 1'b0;
    wa = cur_pos;
    wd = {text_color, cmd.ch};
    if (pend) begin
      we = 1'b1;
      wa = copy_wa;
      wd = rd_data;
    end else if (state == S_FILL) begin
      we = 1'b1;
      wa = cnt;
      wd = BLANK_CELL;
    end else if (state == S_TAIL) begin
      we = 1'b1;
      wa = cnt;
      wd = {text_color, NUL_CODE};
    end else if (take && is_put) begin
      we = 1'b1;
    end
  end

  assign rd_addr = (state == S_COPY) ? (cnt + COLS_A) : AW'(cmd.cidx);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    copy_wa <= cnt;
    if (take) begin
      sbyte_q  <= (cmd.op == OP_PUT || cmd.op == OP_NEWLINE) ? cmd.ch : '0;
      svalid_q <= (cmd.op == OP_PUT || cmd.op == OP_NEWLINE);
      scr_q    <= scroll;
      rok_q    <= (cmd.op == OP_READ) && in_rng;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_FILL;
      cnt     <= '0;
      do_push <= 1'b0;
      pend    <= 1'b0;
      cur_row <= '0;
      cur_col <= '0;
      cur_pos <= '0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      do_push <= do_push_next;
      pend    <= (state == S_COPY);
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      cur_pos <= cur_pos_next;
    end
  end

  always_comb begin
    res_word.cursor_pos = POS_W'(cur_pos_next);
    if (state == S_IDLE) begin
      res_word.cell_data    = '0;
      res_word.serial_byte  = (is_put || is_nl) ? cmd.ch : '0;
      res_word.serial_valid = is_put || is_nl;
      res_word.scrolled     = 1'b0;
    end else begin
      res_word.cell_data    = ((state == S_READ) && rok_q) ? rd_data : '0;
      res_word.serial_byte  = sbyte_q;
      res_word.serial_valid = svalid_q;
      res_word.scrolled     = scr_q;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tcw_result_q.sv
// Two-entry result queue between the engine and the result port.
`default_nettype none

module tcw_result_q
  import tcw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t din,
  output logic      full,
  output logic      empty,
  input  wire logic pop,
  output res_t      dout
);

  res_t       entries [2];
  logic [1:0] count;
  logic       wp;
  logic       rp;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign dout    = entries[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### dv/text_console_writer_test.sv
// Self-checking testbench for the text console writer: random traffic against a built-in predictor.
`default_nettype none

module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // The package names the three used selectors; the fourth must leave the console alone.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Scroll and clear sweep the whole store, and the clearing pass after reset does too.
  // Nothing else comes close, so the limit below leaves a wide margin.
  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_WORDS = 330;
  localparam int PHASES       = 5;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  item_t            item = '0;
  logic             empty;
  logic             pop = 1'b0;
  res_t             result;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predicted console state: the cell store, the cursor and the color register.
  logic [CELL_W-1:0] screen [CELLS];
  int                cur_row;
  int                cur_col;
  logic [7:0]        shade;

  // Words waiting for the driver, and the result words the console owes us.
  item_t words_to_send [$];
  res_t  console_results_due [$];

  int  words_made;
  int  faults;
  int  send_hold;
  int  recv_hold;
  int  span;
  bit  send_quiet;
  bit  recv_quiet;
  int  idle_cycles;

  function automatic void blank_screen();
    for (int k = 0; k < CELLS; k++) begin
      screen[k] = BLANK_CELL;
    end
  endfunction

  // Applies one accepted word to the predicted state and returns the result word it
  // must produce.
  function automatic res_t console_step(input item_t w);
    res_t r;
    r = '0;
    case (w.func)
      FUNC_PUT: begin
        r.serial_byte  = w.char_byte;
        r.serial_valid = 1'b1;
        if (w.char_byte == NEWLINE_CODE) begin
          // A newline only moves the cursor; it leaves the cell under it untouched.
          cur_col = 0;
          cur_row++;
        end else begin
          screen[cur_row * COLUMNS + cur_col] = {shade, w.char_byte};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        if (cur_row >= ROWS) begin
          // Moving past the bottom scrolls everything up one row and leaves an empty
          // bottom row of NUL characters in the current color.
          for (int k = 0; k < CELLS - COLUMNS; k++) begin
            screen[k] = screen[k + COLUMNS];
          end
          for (int k = CELLS - COLUMNS; k < CELLS; k++) begin
            screen[k] = {shade, NUL_CODE};
          end
          cur_row    = ROWS - 1;
          cur_col    = 0;
          r.scrolled = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        // Clear homes the cursor but keeps the color register as it is.
        blank_screen();
        cur_row = 0;
        cur_col = 0;
      end
      FUNC_READ: begin
        // Indexes past the end of the store read as zero.
        if (w.cell_index < CELLS) r.cell_data = screen[w.cell_index];
      end
      default: begin
      end
    endcase
    r.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  function automatic string show_result(input res_t r);
    return $sformatf("cell=%h pos=%0d serial=%h/%b scrolled=%b",
                     r.cell_data, r.cursor_pos, r.serial_byte, r.serial_valid, r.scrolled);
  endfunction

  function automatic void note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Mostly short gaps, a few long ones, and none at all while the side is quiet.
  function automatic int idle_span(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Text is mostly printable, with any byte now and then.
  function automatic logic [CHAR_W-1:0] text_byte();
    if ($urandom_range(0, 9) < 8) return CHAR_W'($urandom_range(8'h20, 8'h7E));
    return CHAR_W'($urandom);
  endfunction

  // Read addresses favor the top and bottom rows, where fresh text lands, and sometimes
  // run past the end of the store.
  function automatic logic [CIDX_W-1:0] pick_cell();
    case ($urandom_range(0, 3))
      0, 1:    return CIDX_W'($urandom_range(0, CELLS - 1));
      2: begin
        if ($urandom_range(0, 1) == 0) return CIDX_W'($urandom_range(0, 2 * COLUMNS - 1));
        return CIDX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
      end
      default: return CIDX_W'($urandom);
    endcase
  endfunction

  function automatic void add_word(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                                   input logic [CIDX_W-1:0] idx);
    item_t w;
    w.func       = f;
    w.char_byte  = ch;
    w.cell_index = idx;
    words_to_send.push_back(w);
    words_made++;
  endfunction

  function automatic void add_char(input logic [CHAR_W-1:0] ch);
    add_word(FUNC_PUT, ch, CIDX_W'($urandom));
  endfunction

  function automatic void add_read(input logic [CIDX_W-1:0] idx);
    add_word(FUNC_READ, CHAR_W'($urandom), idx);
  endfunction

  // Random traffic shaped like terminal use: lines of text ending in a newline, runs of
  // newlines that reach the bottom and scroll, bursts of reads, the odd clear, and some
  // words with every field random.
  task automatic queue_random(input int count);
    int stop_at;
    int n;
    int pick;
    stop_at = words_made + count;
    while (words_made < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        n = ($urandom_range(0, 19) == 0) ? COLUMNS : $urandom_range(0, 100);
        for (int k = 0; k < n; k++) begin
          add_char(text_byte());
          if ($urandom_range(0, 9) == 0) add_read(pick_cell());
        end
        if ($urandom_range(0, 4) != 0) add_char(NEWLINE_CODE);
      end else if (pick < 65) begin
        n = $urandom_range(1, ROWS + 1);
        for (int k = 0; k < n; k++) add_char(NEWLINE_CODE);
      end else if (pick < 80) begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) add_read(pick_cell());
      end else if (pick < 84) begin
        add_word(FUNC_CLEAR, CHAR_W'($urandom), CIDX_W'($urandom));
      end else begin
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
          add_word(FUNC_W'($urandom), CHAR_W'($urandom), CIDX_W'($urandom));
        end
      end
    end
  endtask

  // Waits until every word has gone in and every result word has come back. Sampled on
  // the falling edge so that the driver's and monitor's updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (push || words_to_send.size() != 0 || console_results_due.size() != 0);
  endtask

  // A setup phase and an access phase; the register takes the value at the edge that
  // ends the access phase with pready high.
  task automatic write_color(input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TEXT_COLOR, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shade = value;
  endtask

  // Driver: offers the next pending word, holds it while full is high, and inserts
  // random gaps after each accepted word. Every accepted word is predicted right away.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) console_results_due.push_back(console_step(item));
      if (!(push && full)) begin
        if (send_hold > 0) begin
          push <= 1'b0;
          send_hold--;
        end else if (words_to_send.size() != 0) begin
          item      <= words_to_send.pop_front();
          push      <= 1'b1;
          send_hold = idle_span(send_quiet);
        end else begin
          push <= 1'b0;
        end
      end
      if ($urandom_range(0, 299) == 0) send_quiet = !send_quiet;
    end
  end

  // Monitor: takes result words with random stalls and checks each one against the
  // oldest prediction, field by field.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (console_results_due.size() == 0) begin
          note_fault($sformatf("result word with nothing expected: %s", show_result(result)));
        end else begin
          if (result.cell_data    !== console_results_due[0].cell_data    ||
              result.cursor_pos   !== console_results_due[0].cursor_pos   ||
              result.serial_byte  !== console_results_due[0].serial_byte  ||
              result.serial_valid !== console_results_due[0].serial_valid ||
              result.scrolled     !== console_results_due[0].scrolled) begin
            note_fault($sformatf("expected %s, got %s",
                                 show_result(console_results_due[0]), show_result(result)));
          end
          void'(console_results_due.pop_front());
        end
        span = idle_span(recv_quiet);
        if (span != 0) begin
          pop <= 1'b0;
          recv_hold = span;
        end
      end else if (!pop) begin
        if (recv_hold <= 1) pop <= 1'b1;
        recv_hold--;
      end
      if ($urandom_range(0, 299) == 0) recv_quiet = !recv_quiet;
    end
  end

  // Watchdog: a run that accepts nothing for too long is hung.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((push && !full) || (pop && !empty) || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("text_console_writer_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] phase_shade;
    blank_screen();
    cur_row = 0;
    cur_col = 0;
    shade   = TEXT_COLOR_INIT;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed opening, in the reset color: blank cells at both ends of the store,
    // reads past its end, extreme character bytes including NUL, a newline that writes
    // no cell, the unused selector with every bit set, and a clear after text.
    add_read(CIDX_W'(0));
    add_read(CIDX_W'(CELLS - 1));
    add_read(CIDX_W'(CELLS));
    add_read('1);
    add_char(8'h41);
    add_char(NUL_CODE);
    add_char(8'hFF);
    add_char(NEWLINE_CODE);
    add_char(8'h7F);
    add_read(CIDX_W'(0));
    add_read(CIDX_W'(1));
    add_read(CIDX_W'(2));
    add_read(CIDX_W'(COLUMNS));
    add_read(CIDX_W'(COLUMNS + 1));
    add_word(FUNC_UNUSED, '1, '1);
    add_word(FUNC_UNUSED, '0, '0);
    add_word(FUNC_CLEAR, '1, '1);
    add_read(CIDX_W'(0));
    add_read(CIDX_W'(COLUMNS));
    add_char(8'h20);
    add_read(CIDX_W'(0));
    wait_drained();

    // Random phases, each in its own color; the first two use the extremes.
    for (int ph = 0; ph < PHASES; ph++) begin
      phase_shade = (ph == 0) ? 8'hFF : (ph == 1) ? 8'h00 : 8'($urandom);
      write_color(phase_shade);
      queue_random(RANDOM_WORDS);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (console_results_due.size() != 0) begin
      note_fault($sformatf("%0d result words never arrived", console_results_due.size()));
    end
    if (faults == 0) begin
      $display("text_console_writer_test passed");
    end else begin
      $display("text_console_writer_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_engine.sv
hw/rtl/tcw_result_q.sv
hw/rtl/text_console_writer.sv
dv/text_console_writer_test.sv
